// ===== sv/four_level_page_table_walker_core_defines.svh =====
// Assertion macros used by the page table walker top level.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FPTW_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define FPTW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

// ===== sv/fptw_pkg.sv =====
// Shared constants, types and codes of the page table walker.
package fptw_pkg;

  localparam int ROOTS        = 4;
  localparam int TABLE_FRAMES = 64;
  localparam int ENTRIES      = 512;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FRAME_W = $clog2(TABLE_FRAMES);
  localparam int ADDR_W  = FRAME_W + IDX_W;
  localparam int DEPTH   = TABLE_FRAMES * ENTRIES;
  localparam int NFT_W   = $clog2(TABLE_FRAMES + 1);
  localparam int ENTRY_W = 64;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int PFN_W   = 40;
  localparam int OFS_W   = 12;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_MAP    = 2'd1;
  localparam logic [1:0] KIND_UNMAP  = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NO_MAP    = 2'd1;
  localparam logic [1:0] STATUS_NO_FRAMES = 2'd2;

  localparam logic [1:0] LEVEL_LEAF = 2'd3;
  localparam logic [1:0] LEVEL_LAST_DIR = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DATA,
    S_ALLOC,
    S_FINISH
  } fptw_state_t;

  // Decoded view of one table entry.
  typedef struct packed {
    logic               present;
    logic               in_range;
    logic [FRAME_W-1:0] frame;
    logic [PFN_W-1:0]   pfn;
    logic [2:0]         flags;
  } entry_info_t;

  // One port cycle of the table store.
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic             clearing;
    logic [NFT_W-1:0] next_free;
  } seq_stat_t;

endpackage

// ===== sv/four_level_page_table_walker_core.sv =====
// Top level of the four-level page table walker with its internal table store.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | into core | in_valid / in_ready   | kind, root_select, virt_addr, phys_addr,
//           |           |                       | page_flags
//   out     | from core | out_valid / out_ready | status, phys_result, leaf_flags
//
// Steps: each level walked takes a read and a data step, but a map/unmap leaf is written in its
// read step; each allocated table takes a write step and the result a finish step, and in_ready
// rises with the result. Reset: the store is swept to zero, one entry a cycle; in_ready stays low.
// Stalls: a waiting result holds only the finish step; the next item is taken meanwhile.
`include "four_level_page_table_walker_core_defines.svh"
module four_level_page_table_walker_core import fptw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      kind,
  input  logic [1:0]      root_select,
  input  logic [VA_W-1:0] virt_addr,
  input  logic [PA_W-1:0] phys_addr,
  input  logic [2:0]      page_flags,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [PA_W-1:0] phys_result,
  output logic [2:0]      leaf_flags
);

  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  seq_stat_t          stat;

  // Sequencer: owns the walk state, the bump allocator and the result register.
  fptw_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .root_select(root_select),
    .virt_addr  (virt_addr),
    .phys_addr  (phys_addr),
    .page_flags (page_flags),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .phys_result(phys_result),
    .leaf_flags (leaf_flags),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .stat       (stat)
  );

  // Table store: TABLE_FRAMES frames of 512 entries, addressed {frame, index}.
  fptw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  // No transfer may be taken while the store is still being swept.
  `FPTW_ASSERT_IMPLIES(a_no_take_in_clear, stat.clearing, !in_ready, "input taken during clear")
  // Store writes happen only while an item is in flight or during the sweep.
  `FPTW_ASSERT_IMPLIES(a_write_busy, ram_req.we, !in_ready, "store write while idle")
  // The bump allocator never runs past the last table frame.
  `FPTW_ASSERT_ALWAYS(a_alloc_bound, stat.next_free <= NFT_W'(TABLE_FRAMES), "allocator overrun")
  // A failed item reports zero address and flags.
  `FPTW_ASSERT_IMPLIES(a_fail_zero, out_valid && status != STATUS_DONE, phys_result == '0 && leaf_flags == '0, "nonzero payload on failure")

endmodule

// ===== sv/fptw_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module fptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fptw_entry.sv =====
// Entry unit: decodes a read table entry and builds directory and leaf entries.
module fptw_entry import fptw_pkg::*; (
  input  logic [ENTRY_W-1:0] rd_entry,
  input  logic [FRAME_W-1:0] alloc_frame,
  input  logic [PA_W-1:0]    leaf_pa,
  input  logic [2:0]         leaf_pf,
  output entry_info_t        info,
  output logic [ENTRY_W-1:0] dir_word,
  output logic [ENTRY_W-1:0] leaf_word
);

  logic [PFN_W-1:0] pfn;

  assign pfn = rd_entry[PFN_W+OFS_W-1:OFS_W];

  always_comb begin
    info.present  = rd_entry[0];
    info.in_range = (pfn < PFN_W'(TABLE_FRAMES));
    info.frame    = pfn[FRAME_W-1:0];
    info.pfn      = pfn;
    // Pack flags as no-execute, user, writable.
    info.flags    = {rd_entry[ENTRY_W-1], rd_entry[2], rd_entry[1]};
  end

  // Directory entry: present, writable and user over the new table frame.
  assign dir_word = {12'b0, PFN_W'(alloc_frame), 9'b0, 3'b111};

  assign leaf_word = {leaf_pf[2], 11'b0, leaf_pa[PA_W-1:OFS_W], 9'b0,
                      leaf_pf[1], leaf_pf[0], 1'b1};

endmodule

// ===== sv/fptw_seq.sv =====
// Walk sequencer: clearing pass, level walk, allocation and result register.
module fptw_seq import fptw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [1:0]         root_select,
  input  logic [VA_W-1:0]    virt_addr,
  input  logic [PA_W-1:0]    phys_addr,
  input  logic [2:0]         page_flags,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [PA_W-1:0]    phys_result,
  output logic [2:0]         leaf_flags,
  output ram_req_t           ram_req,
  input  logic [ENTRY_W-1:0] ram_rdata,
  output seq_stat_t          stat
);

  fptw_state_t state, state_next;

  logic [ADDR_W-1:0]  clr_addr;
  logic [NFT_W-1:0]   next_free;
  logic [FRAME_W-1:0] frame;
  logic [1:0]         level;
  logic [1:0]         item_kind;
  logic [VA_W-1:0]    item_va;
  logic [PA_W-1:0]    item_pa;
  logic [2:0]         item_pf;
  logic [1:0]         res_status;
  logic [PA_W-1:0]    res_phys;
  logic [2:0]         res_flags;

  logic               accept;
  logic               item_ok;
  logic               follow_ok;
  logic               no_room;
  logic               load_out;
  logic [IDX_W-1:0]   ix;
  logic [ADDR_W-1:0]  slot;
  logic [NFT_W-1:0]   need;
  logic [NFT_W-1:0]   avail;
  entry_info_t        ent;
  logic [ENTRY_W-1:0] dir_word;
  logic [ENTRY_W-1:0] leaf_word;

  fptw_entry u_entry (
    .rd_entry   (ram_rdata),
    .alloc_frame(next_free[FRAME_W-1:0]),
    .leaf_pa    (item_pa),
    .leaf_pf    (item_pf),
    .info       (ent),
    .dir_word   (dir_word),
    .leaf_word  (leaf_word)
  );

  always_comb begin
    unique case (level)
      2'd0: ix = item_va[47:39];
      2'd1: ix = item_va[38:30];
      2'd2: ix = item_va[29:21];
      2'd3: ix = item_va[20:12];
    endcase
  end

  assign slot      = {frame, ix};
  assign accept    = in_valid && in_ready;
  assign item_ok   = (32'(root_select) < 32'(ROOTS)) &&
                     (kind == KIND_LOOKUP || kind == KIND_MAP || kind == KIND_UNMAP);
  assign follow_ok = ent.present && ent.in_range;
  assign need      = NFT_W'(LEVEL_LEAF - level);
  assign avail     = (next_free < NFT_W'(TABLE_FRAMES)) ?
                     NFT_W'(TABLE_FRAMES) - next_free : '0;
  assign no_room   = need > avail;
  assign load_out  = (state == S_FINISH) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == '1) state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = item_ok ? S_READ : S_FINISH;
      S_READ: begin
        if (level == LEVEL_LEAF && item_kind != KIND_LOOKUP) state_next = S_FINISH;
        else state_next = S_DATA;
      end
      S_DATA: begin
        if (level == LEVEL_LEAF) state_next = S_FINISH;
        else if (follow_ok) state_next = S_READ;
        else if (item_kind == KIND_MAP && !no_room) state_next = S_ALLOC;
        else state_next = S_FINISH;
      end
      S_ALLOC:  if (level == LEVEL_LAST_DIR) state_next = S_READ;
      S_FINISH: if (load_out) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // Handshake and store port.
  always_comb begin
    in_ready      = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = slot;
    ram_req.wdata = '0;
    ram_req.raddr = slot;
    unique case (state)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
      end
      S_IDLE: in_ready = 1'b1;
      S_READ: begin
        if (level == LEVEL_LEAF && item_kind != KIND_LOOKUP) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = (item_kind == KIND_MAP) ? leaf_word : '0;
        end
      end
      S_ALLOC: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = dir_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      next_free <= NFT_W'(ROOTS);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_ALLOC) begin
        next_free <= next_free + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          item_kind  <= kind;
          item_va    <= virt_addr;
          item_pa    <= phys_addr;
          item_pf    <= page_flags;
          frame      <= FRAME_W'(root_select);
          level      <= '0;
          res_status <= STATUS_NO_MAP;
          res_phys   <= '0;
          res_flags  <= '0;
        end
      end
      S_READ: begin
        if (level == LEVEL_LEAF && item_kind != KIND_LOOKUP) begin
          res_status <= STATUS_DONE;
        end
      end
      S_DATA: begin
        if (level == LEVEL_LEAF) begin
          if (ent.present) begin
            res_status <= STATUS_DONE;
            res_phys   <= {ent.pfn, item_va[OFS_W-1:0]};
            res_flags  <= ent.flags;
          end
        end else if (follow_ok) begin
          frame <= ent.frame;
          level <= level + 2'd1;
        end else if (item_kind == KIND_MAP && no_room) begin
          res_status <= STATUS_NO_FRAMES;
        end
      end
      S_ALLOC: begin
        // Hop into the fresh table; it is all zero, so every lower level misses too.
        frame <= next_free[FRAME_W-1:0];
        level <= level + 2'd1;
      end
      S_FINISH: begin
        if (load_out) begin
          status      <= res_status;
          phys_result <= res_phys;
          leaf_flags  <= res_flags;
        end
      end
      default: ;
    endcase
  end

  assign stat.clearing  = (state == S_CLEAR);
  assign stat.next_free = next_free;

endmodule
